[hdl/tte_pkg.sv]
// ----------------------------------------------------------------------------
// tte_pkg
// shared constants, types and helper functions of the text terminal engine
// ----------------------------------------------------------------------------
package tte_pkg;

   localparam int ROWS       = 25;
   localparam int COLS       = 80;
   localparam int MAX_PARAMS = 8;
   localparam int CELLS      = ROWS * COLS;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int PC_W   = $clog2(MAX_PARAMS + 1);
   localparam int PI_W   = $clog2(MAX_PARAMS);

   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] FINAL_LO = 8'h40;
   localparam logic [7:0] FINAL_HI = 8'h7E;
   localparam logic [7:0] BLANK_ATTR = 8'h07;

   localparam logic [2:0] SGR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

   typedef enum logic [3:0] {
      BC_CTRL, BC_ESC, BC_BS, BC_TAB, BC_LF, BC_CR,
      BC_DIGIT, BC_SEMI, BC_PRIV, BC_FINAL, BC_TEXT
   } byte_class_type;

   typedef enum logic [3:0] {
      FN_NONE, FN_CUP, FN_CUU, FN_CUD, FN_CUF, FN_CUB, FN_ED, FN_EL,
      FN_SGR, FN_STBM, FN_SCP, FN_RCP, FN_SU, FN_SD, FN_IL
   } fin_type;

   typedef struct packed {
      logic              is_read;
      logic [7:0]        data_byte;
      byte_class_type    cls;
      fin_type           fin;
      logic              is_lbr;
      logic              read_ok;
      logic [ADDR_W-1:0] read_addr;
   } op_type;

   function automatic logic [2:0] color_map(input logic [2:0] idx);
      return SGR_MAP[idx];
   endfunction

   function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic [15:0] p);
      logic [7:0]  r;
      logic [15:0] d;
      r = a;
      d = 16'd0;
      if (p == 16'd0) begin
         r = BLANK_ATTR;
      end else if (p == 16'd1) begin
         r = a | 8'h08;
      end else if (p >= 16'd30 && p <= 16'd37) begin
         d = p - 16'd30;
         r = (a & 8'hF8) | {5'd0, color_map(d[2:0])};
      end else if (p >= 16'd40 && p <= 16'd47) begin
         d = p - 16'd40;
         r = (a & 8'h8F) | {1'b0, color_map(d[2:0]), 4'd0};
      end else if (p >= 16'd90 && p <= 16'd97) begin
         d = p - 16'd90;
         r = (a & 8'hF0) | {5'd0, color_map(d[2:0])} | 8'h08;
      end
      return r;
   endfunction

endpackage

[hdl/tte_if.sv]
// ----------------------------------------------------------------------------
// tte_req_if / tte_rsp_if
// valid/ready channels of the text terminal engine
// ----------------------------------------------------------------------------
interface tte_req_if;
   import tte_pkg::*;
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [7:0]       data_byte;
   logic [ROW_W-1:0] read_row;
   logic [COL_W-1:0] read_col;
   modport source(output valid, cmd, data_byte, read_row, read_col, input ready);
   modport sink(input valid, cmd, data_byte, read_row, read_col, output ready);
endinterface

interface tte_rsp_if;
   import tte_pkg::*;
   logic             valid;
   logic             ready;
   logic [7:0]       cell_char;
   logic [7:0]       cell_attr;
   logic [ROW_W-1:0] cursor_row;
   logic [COL_W-1:0] cursor_col;
   modport source(output valid, cell_char, cell_attr, cursor_row, cursor_col, input ready);
   modport sink(input valid, cell_char, cell_attr, cursor_row, cursor_col, output ready);
endinterface

[hdl/tte_front.sv]
// ----------------------------------------------------------------------------
// tte_front
// accepts request words and classifies them into queue entries
// ----------------------------------------------------------------------------
module tte_front (
   tte_req_if.sink         req_bus,
   input  logic            q_full,
   output logic            q_push,
   output tte_pkg::op_type q_data
);
   import tte_pkg::*;

   logic [7:0] b;

   assign b             = req_bus.data_byte;
   assign req_bus.ready = !q_full;
   assign q_push        = req_bus.valid && !q_full;

   always_comb begin
      q_data.is_read   = req_bus.cmd;
      q_data.data_byte = b;
      q_data.is_lbr    = (b == CH_LBR);
      q_data.read_ok   = (32'(req_bus.read_row) < ROWS) && (32'(req_bus.read_col) < COLS);
      q_data.read_addr = ADDR_W'(req_bus.read_row * COLS) + ADDR_W'(req_bus.read_col);

      priority if (b == CH_ESC)                 q_data.cls = BC_ESC;
      else if (b == CH_BS)                      q_data.cls = BC_BS;
      else if (b == CH_TAB)                     q_data.cls = BC_TAB;
      else if (b == CH_LF)                      q_data.cls = BC_LF;
      else if (b == CH_CR)                      q_data.cls = BC_CR;
      else if (b < CH_SPACE)                    q_data.cls = BC_CTRL;
      else if (b >= "0" && b <= "9")            q_data.cls = BC_DIGIT;
      else if (b == ";")                        q_data.cls = BC_SEMI;
      else if (b == "?" || b == ">" || b == "=") q_data.cls = BC_PRIV;
      else if (b >= FINAL_LO && b <= FINAL_HI)  q_data.cls = BC_FINAL;
      else                                      q_data.cls = BC_TEXT;

      unique case (b)
         "H", "f": q_data.fin = FN_CUP;
         "A":      q_data.fin = FN_CUU;
         "B":      q_data.fin = FN_CUD;
         "C":      q_data.fin = FN_CUF;
         "D":      q_data.fin = FN_CUB;
         "J":      q_data.fin = FN_ED;
         "K":      q_data.fin = FN_EL;
         "m":      q_data.fin = FN_SGR;
         "r":      q_data.fin = FN_STBM;
         "s":      q_data.fin = FN_SCP;
         "u":      q_data.fin = FN_RCP;
         "M", "S": q_data.fin = FN_SU;
         "T":      q_data.fin = FN_SD;
         "L":      q_data.fin = FN_IL;
         default:  q_data.fin = FN_NONE;
      endcase
   end

endmodule

[hdl/tte_queue.sv]
// ----------------------------------------------------------------------------
// tte_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module tte_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tte_pkg::op_type push_data,
   output logic            full,
   input  logic            pop,
   output tte_pkg::op_type head,
   output logic            not_empty
);
   import tte_pkg::*;

   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/tte_back.sv]
// ----------------------------------------------------------------------------
// tte_back
// escape parser, cursor state and grid memory sequencer
// ----------------------------------------------------------------------------
module tte_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  tte_pkg::op_type q_head,
   output logic            q_pop,
   tte_rsp_if.source       rsp_bus
);
   import tte_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_BLANK = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;
   localparam logic [2:0] ST_GLYPH = 3'd6;
   localparam logic [2:0] ST_SGR   = 3'd7;

   localparam logic [1:0] PS_GROUND = 2'd0;
   localparam logic [1:0] PS_ESC    = 2'd1;
   localparam logic [1:0] PS_CSI    = 2'd2;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

   // grid memory, attr in the high byte
   logic [15:0] grid_mem [CELLS];
   logic [15:0] rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [15:0]       mem_wd;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        ps_ff, ps_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [15:0]       acc_ff, acc_in;
   logic [15:0]       parr_ff [MAX_PARAMS];
   logic              parr_we;
   logic [PI_W-1:0]   parr_wa;
   logic [ROW_W-1:0]  cur_r_ff, cur_r_in, top_ff, top_in, bot_ff, bot_in, sav_r_ff, sav_r_in;
   logic [COL_W-1:0]  cur_c_ff, cur_c_in, sav_c_ff, sav_c_in;
   logic [7:0]        attr_ff, attr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] blk_addr_ff, blk_addr_in, blk_end_ff, blk_end_in;
   logic [ROW_W-1:0]  sh_row_ff, sh_row_in, sh_top_ff, sh_top_in, sh_bot_ff, sh_bot_in;
   logic [ROW_W-1:0]  sh_n_ff, sh_n_in;
   logic [COL_W-1:0]  sh_col_ff, sh_col_in;
   logic              sh_up_ff, sh_up_in;
   logic              pw_valid_ff, pw_valid_in, pw_copy_ff, pw_copy_in;
   logic [ADDR_W-1:0] pw_addr_ff, pw_addr_in;
   logic              glyph_pend_ff, glyph_pend_in;
   logic [7:0]        glyph_ff, glyph_in;
   logic [PI_W-1:0]   sgr_i_ff, sgr_i_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_char_ff, out_char_in, out_attr_ff, out_attr_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;

   // decode helpers
   logic [15:0]       p0, p1, amt, sgr_p, t_val, b_val;
   logic [16:0]       sum17;
   logic              b_bad;
   logic [ROW_W-1:0]  n_cnt;
   logic [ADDR_W-1:0] row_base, cur_lin, row_end, lin_inc;
   logic [ADDR_W:0]   sh_dst_w, sh_src_w, sh_nofs;
   logic [ROW_W:0]    sh_sum;
   logic              sh_copy;
   logic [19:0]       acc_x10;
   logic [PC_W-1:0]   pc_eff;
   logic [COL_W:0]    tab_c;
   logic [ROW_W-1:0]  wrap_r;
   logic              done, start_blank, start_shift, shift_up;
   logic [7:0]        done_char, done_attr;
   logic [ADDR_W-1:0] blank_s, blank_e;
   logic [ROW_W-1:0]  shift_top, shift_bot, shift_n;
   logic [15:0]       blank_word;

   assign blank_word = {attr_ff, CH_SPACE};

   always_comb begin
      p0 = (pc_ff == '0) ? 16'd0 : ((pc_ff == PC_W'(1)) ? acc_ff : parr_ff[0]);
      p1 = (pc_ff > PC_W'(1)) ? ((pc_ff == PC_W'(2)) ? acc_ff : parr_ff[1]) : 16'd0;
      amt = (p0 == 16'd0) ? 16'd1 : p0;
      n_cnt = (p0 == 16'd0) ? ROW_W'(1) : ((32'(p0) > ROWS) ? ROW_W'(ROWS) : p0[ROW_W-1:0]);
      sgr_p = (PC_W'(sgr_i_ff) == pc_ff - PC_W'(1)) ? acc_ff : parr_ff[sgr_i_ff];
      row_base = ADDR_W'(cur_r_ff * COLS);
      cur_lin  = row_base + ADDR_W'(cur_c_ff);
      row_end  = row_base + ADDR_W'(COLS);
      lin_inc  = (cur_lin + ADDR_W'(1) < row_end) ? cur_lin + ADDR_W'(1) : row_end;
      acc_x10  = {acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0}
                 + {12'd0, q_head.data_byte - "0"};
      pc_eff   = (pc_ff == '0) ? PC_W'(1) : pc_ff;
      tab_c    = ({1'b0, cur_c_ff} + (COL_W + 1)'(8)) & ~(COL_W + 1)'(7);
      wrap_r   = (cur_r_ff < LAST_ROW) ? cur_r_ff + ROW_W'(1) : cur_r_ff;
      // scroll region from csi parameters
      t_val = (pc_ff != '0 && p0 != 16'd0) ? p0 - 16'd1 : 16'd0;
      b_bad = (pc_ff > PC_W'(1)) && (p1 == 16'd0);
      b_val = (pc_ff > PC_W'(1)) ? ((32'(p1) > ROWS) ? 16'(ROWS - 1) : p1 - 16'd1)
                                 : 16'(ROWS - 1);
      // shift sweep addresses
      sh_dst_w = (ADDR_W + 1)'(sh_row_ff * COLS) + (ADDR_W + 1)'(sh_col_ff);
      sh_nofs  = (ADDR_W + 1)'(sh_n_ff * COLS);
      if (sh_up_ff) begin
         sh_sum   = {1'b0, sh_row_ff} + {1'b0, sh_n_ff};
         sh_copy  = (sh_sum <= {1'b0, sh_bot_ff});
         sh_src_w = sh_dst_w + sh_nofs;
      end else begin
         sh_sum   = {1'b0, sh_top_ff} + {1'b0, sh_n_ff};
         sh_copy  = ({1'b0, sh_row_ff} >= sh_sum);
         sh_src_w = sh_dst_w - sh_nofs;
      end
   end

   always_comb begin
      state_in = state_ff;  ps_in = ps_ff;  pc_in = pc_ff;  acc_in = acc_ff;
      parr_we = 1'b0;  parr_wa = '0;
      cur_r_in = cur_r_ff;  cur_c_in = cur_c_ff;  top_in = top_ff;  bot_in = bot_ff;
      sav_r_in = sav_r_ff;  sav_c_in = sav_c_ff;  attr_in = attr_ff;
      clr_addr_in = clr_addr_ff;  blk_addr_in = blk_addr_ff;  blk_end_in = blk_end_ff;
      sh_row_in = sh_row_ff;  sh_col_in = sh_col_ff;  sh_top_in = sh_top_ff;
      sh_bot_in = sh_bot_ff;  sh_n_in = sh_n_ff;  sh_up_in = sh_up_ff;
      pw_valid_in = 1'b0;  pw_addr_in = pw_addr_ff;  pw_copy_in = pw_copy_ff;
      glyph_pend_in = glyph_pend_ff;  glyph_in = glyph_ff;  sgr_i_in = sgr_i_ff;
      rd_ok_in = rd_ok_ff;
      out_valid_in = out_valid_ff;  out_char_in = out_char_ff;  out_attr_in = out_attr_ff;
      out_row_in = out_row_ff;  out_col_in = out_col_ff;
      q_pop = 1'b0;  done = 1'b0;  done_char = 8'd0;  done_attr = 8'd0;
      start_blank = 1'b0;  blank_s = '0;  blank_e = '0;
      start_shift = 1'b0;  shift_up = 1'b1;
      shift_top = top_ff;  shift_bot = bot_ff;  shift_n = ROW_W'(1);
      mem_we = 1'b0;  mem_wa = pw_addr_ff;  mem_wd = blank_word;  mem_ra = '0;
      sum17 = 17'd0;

      // delayed write of the shift pipeline
      if (pw_valid_ff) begin
         mem_we = 1'b1;
         mem_wa = pw_addr_ff;
         mem_wd = pw_copy_ff ? rd_data_ff : blank_word;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_addr_ff;
            mem_wd = {BLANK_ATTR, CH_SPACE};
            if (clr_addr_ff == ADDR_W'(CELLS - 1)) state_in = ST_IDLE;
            else clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (q_valid && !out_valid_ff) begin
               q_pop = 1'b1;
               if (q_head.is_read) begin
                  mem_ra   = q_head.read_addr;
                  rd_ok_in = q_head.read_ok;
                  state_in = ST_READ;
               end else begin
                  unique case (ps_ff)
                     PS_ESC: begin
                        done = 1'b1;
                        if (q_head.is_lbr) begin
                           ps_in = PS_CSI;  pc_in = '0;  acc_in = 16'd0;
                        end else begin
                           ps_in = PS_GROUND;
                        end
                     end
                     PS_CSI: begin
                        unique case (q_head.cls)
                           BC_DIGIT: begin
                              done   = 1'b1;
                              pc_in  = pc_eff;
                              acc_in = (acc_x10 > 20'hFFFF) ? 16'hFFFF : acc_x10[15:0];
                           end
                           BC_SEMI: begin
                              done = 1'b1;
                              if (32'(pc_eff) < MAX_PARAMS) begin
                                 parr_we = 1'b1;
                                 parr_wa = PI_W'(pc_eff - PC_W'(1));
                                 acc_in  = 16'd0;
                                 pc_in   = pc_eff + PC_W'(1);
                              end else begin
                                 pc_in = pc_eff;
                              end
                           end
                           BC_PRIV: done = 1'b1;
                           BC_FINAL: begin
                              ps_in = PS_GROUND;
                              unique case (q_head.fin)
                                 FN_CUP: begin
                                    done = 1'b1;
                                    cur_r_in = (p0 == 16'd0) ? '0 : ((32'(p0) >= ROWS)
                                               ? LAST_ROW : ROW_W'(p0 - 16'd1));
                                    cur_c_in = (p1 == 16'd0) ? '0 : ((32'(p1) >= COLS)
                                               ? LAST_COL : COL_W'(p1 - 16'd1));
                                 end
                                 FN_CUU: begin
                                    done = 1'b1;
                                    cur_r_in = (amt > 16'(cur_r_ff)) ? '0
                                               : ROW_W'(16'(cur_r_ff) - amt);
                                    cur_c_in = (cur_c_ff > LAST_COL) ? LAST_COL : cur_c_ff;
                                 end
                                 FN_CUD: begin
                                    done = 1'b1;
                                    sum17 = 17'(cur_r_ff) + 17'(amt);
                                    cur_r_in = (32'(sum17) >= ROWS) ? LAST_ROW
                                               : ROW_W'(sum17);
                                    cur_c_in = (cur_c_ff > LAST_COL) ? LAST_COL : cur_c_ff;
                                 end
                                 FN_CUF: begin
                                    done = 1'b1;
                                    sum17 = 17'(cur_c_ff) + 17'(amt);
                                    cur_c_in = (32'(sum17) >= COLS) ? LAST_COL
                                               : COL_W'(sum17);
                                 end
                                 FN_CUB: begin
                                    done = 1'b1;
                                    cur_c_in = (amt > 16'(cur_c_ff)) ? '0
                                               : COL_W'(16'(cur_c_ff) - amt);
                                    if (cur_c_in > LAST_COL) cur_c_in = LAST_COL;
                                 end
                                 FN_ED: begin
                                    priority if (p0 == 16'd2 || p0 == 16'd3) begin
                                       start_blank = 1'b1;
                                       blank_e = ADDR_W'(CELLS);
                                    end else if (p0 == 16'd0) begin
                                       start_blank = 1'b1;
                                       blank_s = cur_lin;
                                       blank_e = ADDR_W'(CELLS);
                                    end else if (p0 == 16'd1) begin
                                       start_blank = 1'b1;
                                       blank_e = lin_inc;
                                    end else begin
                                       done = 1'b1;
                                    end
                                 end
                                 FN_EL: begin
                                    start_blank = 1'b1;
                                    priority if (p0 == 16'd0) begin
                                       blank_s = cur_lin;   blank_e = row_end;
                                    end else if (p0 == 16'd1) begin
                                       blank_s = row_base;  blank_e = lin_inc;
                                    end else begin
                                       blank_s = row_base;  blank_e = row_end;
                                    end
                                 end
                                 FN_SGR: begin
                                    if (pc_ff == '0) begin
                                       attr_in = BLANK_ATTR;
                                       done = 1'b1;
                                    end else begin
                                       sgr_i_in = '0;
                                       state_in = ST_SGR;
                                    end
                                 end
                                 FN_STBM: begin
                                    done = 1'b1;
                                    if (b_bad || t_val > b_val) begin
                                       top_in = '0;  bot_in = LAST_ROW;
                                    end else begin
                                       top_in = ROW_W'(t_val);  bot_in = ROW_W'(b_val);
                                    end
                                 end
                                 FN_SCP: begin
                                    done = 1'b1;
                                    sav_r_in = cur_r_ff;  sav_c_in = cur_c_ff;
                                 end
                                 FN_RCP: begin
                                    done = 1'b1;
                                    cur_r_in = sav_r_ff;
                                    cur_c_in = (sav_c_ff > LAST_COL) ? LAST_COL : sav_c_ff;
                                 end
                                 FN_SU: begin
                                    start_shift = 1'b1;  shift_n = n_cnt;
                                 end
                                 FN_SD: begin
                                    start_shift = 1'b1;  shift_up = 1'b0;  shift_n = n_cnt;
                                 end
                                 FN_IL: begin
                                    start_shift = 1'b1;  shift_up = 1'b0;  shift_n = n_cnt;
                                    shift_top = cur_r_ff;
                                    shift_bot = (cur_r_ff <= bot_ff) ? bot_ff : cur_r_ff;
                                 end
                                 default: done = 1'b1;
                              endcase
                           end
                           default: begin
                              done  = 1'b1;
                              ps_in = PS_GROUND;
                           end
                        endcase
                     end
                     default: begin
                        // ground state
                        ps_in = PS_GROUND;
                        unique case (q_head.cls)
                           BC_ESC: begin
                              done = 1'b1;  ps_in = PS_ESC;
                           end
                           BC_BS: begin
                              done = 1'b1;
                              if (cur_c_ff != '0) cur_c_in = cur_c_ff - COL_W'(1);
                           end
                           BC_TAB: begin
                              done = 1'b1;
                              cur_c_in = (32'(tab_c) >= COLS) ? LAST_COL : COL_W'(tab_c);
                           end
                           BC_LF: begin
                              cur_c_in = '0;
                              if (cur_r_ff == bot_ff) begin
                                 start_shift = 1'b1;  glyph_pend_in = 1'b0;
                              end else begin
                                 done = 1'b1;  cur_r_in = wrap_r;
                              end
                           end
                           BC_CR: begin
                              done = 1'b1;  cur_c_in = '0;
                           end
                           BC_CTRL: done = 1'b1;
                           default: begin
                              if (32'(cur_c_ff) >= COLS) begin
                                 if (cur_r_ff == bot_ff) begin
                                    // scroll first, glyph goes in afterwards
                                    cur_c_in = '0;
                                    start_shift = 1'b1;
                                    glyph_pend_in = 1'b1;
                                    glyph_in = q_head.data_byte;
                                 end else begin
                                    done = 1'b1;
                                    cur_r_in = wrap_r;
                                    cur_c_in = COL_W'(1);
                                    mem_we = 1'b1;
                                    mem_wa = ADDR_W'(wrap_r * COLS);
                                    mem_wd = {attr_ff, q_head.data_byte};
                                 end
                              end else begin
                                 done = 1'b1;
                                 cur_c_in = cur_c_ff + COL_W'(1);
                                 mem_we = 1'b1;
                                 mem_wa = cur_lin;
                                 mem_wd = {attr_ff, q_head.data_byte};
                              end
                           end
                        endcase
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            done = 1'b1;
            done_char = rd_ok_ff ? rd_data_ff[7:0] : 8'd0;
            done_attr = rd_ok_ff ? rd_data_ff[15:8] : 8'd0;
         end
         ST_BLANK: begin
            mem_we = 1'b1;
            mem_wa = blk_addr_ff;
            mem_wd = blank_word;
            blk_addr_in = blk_addr_ff + ADDR_W'(1);
            if (blk_addr_in == blk_end_ff) done = 1'b1;
         end
         ST_SHIFT: begin
            mem_ra = sh_copy ? sh_src_w[ADDR_W-1:0] : sh_dst_w[ADDR_W-1:0];
            pw_valid_in = 1'b1;
            pw_addr_in  = sh_dst_w[ADDR_W-1:0];
            pw_copy_in  = sh_copy;
            if (sh_col_ff == LAST_COL) begin
               sh_col_in = '0;
               if (sh_up_ff) begin
                  if (sh_row_ff == sh_bot_ff) state_in = ST_DRAIN;
                  else sh_row_in = sh_row_ff + ROW_W'(1);
               end else begin
                  if (sh_row_ff == sh_top_ff) state_in = ST_DRAIN;
                  else sh_row_in = sh_row_ff - ROW_W'(1);
               end
            end else begin
               sh_col_in = sh_col_ff + COL_W'(1);
            end
         end
         ST_DRAIN: begin
            if (glyph_pend_ff) begin
               glyph_pend_in = 1'b0;
               state_in = ST_GLYPH;
            end else begin
               done = 1'b1;
            end
         end
         ST_GLYPH: begin
            done = 1'b1;
            mem_we = 1'b1;
            mem_wa = cur_lin;
            mem_wd = {attr_ff, glyph_ff};
            cur_c_in = cur_c_ff + COL_W'(1);
         end
         ST_SGR: begin
            attr_in = sgr_apply(attr_ff, sgr_p);
            if (PC_W'(sgr_i_ff) == pc_ff - PC_W'(1)) done = 1'b1;
            else sgr_i_in = sgr_i_ff + PI_W'(1);
         end
         default: state_in = ST_IDLE;
      endcase

      if (start_blank) begin
         if (blank_s < blank_e) begin
            blk_addr_in = blank_s;
            blk_end_in  = blank_e;
            state_in    = ST_BLANK;
         end else begin
            done = 1'b1;
         end
      end
      if (start_shift) begin
         sh_up_in  = shift_up;
         sh_top_in = shift_top;
         sh_bot_in = shift_bot;
         sh_n_in   = shift_n;
         sh_row_in = shift_up ? shift_top : shift_bot;
         sh_col_in = '0;
         state_in  = ST_SHIFT;
      end

      if (rsp_bus.valid && rsp_bus.ready) out_valid_in = 1'b0;
      if (done) begin
         out_valid_in = 1'b1;
         out_char_in  = done_char;
         out_attr_in  = done_attr;
         out_row_in   = cur_r_in;
         out_col_in   = cur_c_in;
         state_in     = ST_IDLE;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.cell_char  = out_char_ff;
   assign rsp_bus.cell_attr  = out_attr_ff;
   assign rsp_bus.cursor_row = out_row_ff;
   assign rsp_bus.cursor_col = out_col_ff;

   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[mem_wa] <= mem_wd;
      rd_data_ff <= grid_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (parr_we) parr_ff[parr_wa] <= acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ps_ff         <= PS_GROUND;
         pc_ff         <= '0;
         acc_ff        <= 16'd0;
         cur_r_ff      <= '0;
         cur_c_ff      <= '0;
         top_ff        <= '0;
         bot_ff        <= LAST_ROW;
         sav_r_ff      <= '0;
         sav_c_ff      <= '0;
         attr_ff       <= BLANK_ATTR;
         clr_addr_ff   <= '0;
         pw_valid_ff   <= 1'b0;
         glyph_pend_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ps_ff         <= ps_in;
         pc_ff         <= pc_in;
         acc_ff        <= acc_in;
         cur_r_ff      <= cur_r_in;
         cur_c_ff      <= cur_c_in;
         top_ff        <= top_in;
         bot_ff        <= bot_in;
         sav_r_ff      <= sav_r_in;
         sav_c_ff      <= sav_c_in;
         attr_ff       <= attr_in;
         clr_addr_ff   <= clr_addr_in;
         pw_valid_ff   <= pw_valid_in;
         glyph_pend_ff <= glyph_pend_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_addr_ff <= blk_addr_in;
      blk_end_ff  <= blk_end_in;
      sh_row_ff   <= sh_row_in;
      sh_col_ff   <= sh_col_in;
      sh_top_ff   <= sh_top_in;
      sh_bot_ff   <= sh_bot_in;
      sh_n_ff     <= sh_n_in;
      sh_up_ff    <= sh_up_in;
      pw_addr_ff  <= pw_addr_in;
      pw_copy_ff  <= pw_copy_in;
      glyph_ff    <= glyph_in;
      sgr_i_ff    <= sgr_i_in;
      rd_ok_ff    <= rd_ok_in;
      out_char_ff <= out_char_in;
      out_attr_ff <= out_attr_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
   end

endmodule

[hdl/ansi_text_terminal_engine.sv]
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine
// text-mode terminal with an escape sequence parser and a 25 x 80 cell grid
// ----------------------------------------------------------------------------
// usage
//   req_bus carries one word per item: cmd 0 feeds data_byte to the parser,
//   cmd 1 reads the cell at read_row / read_col
//   rsp_bus returns exactly one word per item: the cell (zero for feeds and
//   for reads outside the grid) and the cursor after the item
// processing
//   plain bytes and cursor moves finish in the idle state, reads pass
//   through the registered grid memory output
//   erases blank one cell per cycle, up to all 2000 cells of the screen
//   scrolls and line inserts copy or blank one cell per cycle over the
//   touched rows, then write a glyph that waited for the scroll;
//   the single grid memory write port sets this rate
//   sgr applies one parameter per cycle
// reset
//   after reset a clearing pass writes spaces with attribute 0x07 to all
//   2000 cells; up to two words are queued meanwhile and are carried out
//   once it ends
// stalls
//   a two-word queue lets the front keep taking words while the back works
//   or while rsp_bus is stalled; the back waits for the result register
// ----------------------------------------------------------------------------
module ansi_text_terminal_engine (
   input  logic      clock,
   input  logic      reset,
   tte_req_if.sink   req_bus,
   tte_rsp_if.source rsp_bus
);
   import tte_pkg::*;

   // front to queue
   logic   q_push, q_full;
   op_type q_in;
   // queue to back
   logic   q_pop, q_valid;
   op_type q_head;

   // classify incoming words
   tte_front u_front (
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_in)
   );

   // decouple front and back
   tte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_valid)
   );

   // parser, cursor and grid sequencer
   tte_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

[tb/tte_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tte_checker
// predicts the terminal grid and cursor, compares every rsp_bus word
// ----------------------------------------------------------------------------
module tte_checker (
   input  logic     clock,
   input  logic     reset,
   tte_req_if       req_bus,
   tte_rsp_if       rsp_bus,
   output int       fail_count,
   output int       pending_count
);
   import tte_pkg::*;

   typedef enum logic [1:0] {PS_GROUND, PS_ESC, PS_CSI} parse_type;

   typedef struct packed {
      logic [7:0]       cell_char;
      logic [7:0]       cell_attr;
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
   } cell_word_type;

   logic [7:0] grid_char [CELLS];
   logic [7:0] grid_attr [CELLS];
   int         cur_r, cur_c, top_r, bot_r, save_r, save_c;
   logic [7:0] pen_attr;
   parse_type  pstate;
   int         pcount;
   int         pvals [MAX_PARAMS];
   cell_word_type expected_words [$];

   function automatic void blank(int r, int c0, int c1);
      int c;
      if (r < 0 || r >= ROWS) return;
      if (c0 < 0) c0 = 0;
      if (c1 > COLS) c1 = COLS;
      for (c = c0; c < c1; c++) begin
         grid_char[r*COLS+c] = CH_SPACE;
         grid_attr[r*COLS+c] = pen_attr;
      end
   endfunction

   function automatic void copy_row(int dst, int src);
      int c;
      for (c = 0; c < COLS; c++) begin
         grid_char[dst*COLS+c] = grid_char[src*COLS+c];
         grid_attr[dst*COLS+c] = grid_attr[src*COLS+c];
      end
   endfunction

   function automatic void scroll_up();
      int r;
      for (r = top_r; r < bot_r; r++) copy_row(r, r+1);
      blank(bot_r, 0, COLS);
   endfunction

   function automatic void scroll_down();
      int r;
      for (r = bot_r; r > top_r; r--) copy_row(r, r-1);
      blank(top_r, 0, COLS);
   endfunction

   function automatic void next_line();
      if (cur_r == bot_r) scroll_up();
      else if (cur_r < ROWS-1) cur_r++;
   endfunction

   function automatic void clamp();
      if (cur_c < 0) cur_c = 0;
      if (cur_c >= COLS) cur_c = COLS-1;
      if (cur_r < 0) cur_r = 0;
      if (cur_r >= ROWS) cur_r = ROWS-1;
   endfunction

   function automatic logic [7:0] sgr_step(logic [7:0] a, int p);
      logic [2:0] cmap [8];
      cmap = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
      if (p == 0) return BLANK_ATTR;
      if (p == 1) return a | 8'h08;
      if (p >= 30 && p <= 37) return (a & 8'hF8) | {5'd0, cmap[p-30]};
      if (p >= 40 && p <= 47) return (a & 8'h8F) | {1'b0, cmap[p-40], 4'd0};
      if (p >= 90 && p <= 97) return (a & 8'hF0) | {5'd0, cmap[p-90]} | 8'h08;
      return a;
   endfunction

   function automatic void run_final(logic [7:0] f);
      int p0, p1, n, i, r;
      p0 = pcount > 0 ? pvals[0] : 0;
      p1 = pcount > 1 ? pvals[1] : 0;
      n = p0 ? p0 : 1;
      if (n > ROWS) n = ROWS;
      case (f)
         "H", "f": begin
            cur_r = (pcount > 0 ? p0 : 1) - 1;
            cur_c = (pcount > 1 ? p1 : 1) - 1;
            clamp();
         end
         "A": begin cur_r -= p0 ? p0 : 1; clamp(); end
         "B": begin cur_r += p0 ? p0 : 1; clamp(); end
         "C": begin cur_c += p0 ? p0 : 1; clamp(); end
         "D": begin cur_c -= p0 ? p0 : 1; clamp(); end
         "J": begin
            if (p0 == 2 || p0 == 3) begin
               for (r = 0; r < ROWS; r++) blank(r, 0, COLS);
            end else if (p0 == 0) begin
               blank(cur_r, cur_c, COLS);
               for (r = cur_r+1; r < ROWS; r++) blank(r, 0, COLS);
            end else if (p0 == 1) begin
               for (r = 0; r < cur_r; r++) blank(r, 0, COLS);
               blank(cur_r, 0, cur_c+1);
            end
         end
         "K": begin
            if (p0 == 0) blank(cur_r, cur_c, COLS);
            else if (p0 == 1) blank(cur_r, 0, cur_c+1);
            else blank(cur_r, 0, COLS);
         end
         "m": begin
            if (pcount == 0) pen_attr = BLANK_ATTR;
            for (i = 0; i < pcount; i++) pen_attr = sgr_step(pen_attr, pvals[i]);
         end
         "r": begin
            top_r = (pcount > 0 ? p0 : 1) - 1;
            bot_r = (pcount > 1 ? p1 : ROWS) - 1;
            if (top_r < 0) top_r = 0;
            if (bot_r >= ROWS) bot_r = ROWS-1;
            if (top_r > bot_r) begin top_r = 0; bot_r = ROWS-1; end
         end
         "s": begin save_r = cur_r; save_c = cur_c; end
         "u": begin cur_r = save_r; cur_c = save_c; clamp(); end
         "M", "S": for (i = 0; i < n; i++) scroll_up();
         "T": for (i = 0; i < n; i++) scroll_down();
         "L": for (i = 0; i < n; i++) begin
            for (r = bot_r; r > cur_r; r--) copy_row(r, r-1);
            blank(cur_r, 0, COLS);
         end
         default: ;
      endcase
   endfunction

   function automatic void feed_terminal(logic [7:0] b);
      int v;
      if (pstate == PS_ESC) begin
         if (b == CH_LBR) begin
            pstate = PS_CSI; pcount = 0; pvals[0] = 0;
         end else pstate = PS_GROUND;
      end else if (pstate == PS_CSI) begin
         if (b >= "0" && b <= "9") begin
            if (pcount == 0) pcount = 1;
            v = pvals[pcount-1] * 10 + (b - "0");
            pvals[pcount-1] = v > 65535 ? 65535 : v;
         end else if (b == ";") begin
            if (pcount == 0) pcount = 1;
            if (pcount < MAX_PARAMS) begin pvals[pcount] = 0; pcount++; end
         end else if (b == "?" || b == ">" || b == "=") begin
         end else if (b >= FINAL_LO && b <= FINAL_HI) begin
            run_final(b); pstate = PS_GROUND;
         end else pstate = PS_GROUND;
      end else begin
         case (b)
            CH_ESC: pstate = PS_ESC;
            CH_BEL: ;
            CH_BS: begin
               if (cur_c > 0) cur_c--;
               if (cur_c >= COLS) cur_c = COLS-1;
            end
            CH_TAB: begin
               cur_c = (cur_c + 8) & ~7;
               if (cur_c >= COLS) cur_c = COLS-1;
            end
            CH_LF: begin cur_c = 0; next_line(); end
            CH_CR: cur_c = 0;
            default: if (b >= CH_SPACE) begin
               if (cur_c >= COLS) begin cur_c = 0; next_line(); end
               grid_char[cur_r*COLS+cur_c] = b;
               grid_attr[cur_r*COLS+cur_c] = pen_attr;
               cur_c++;
            end
         endcase
      end
   endfunction

   assign pending_count = expected_words.size();

   always @(posedge clock) begin
      cell_word_type w, got;
      if (reset) begin
         foreach (grid_char[i]) begin grid_char[i] = CH_SPACE; grid_attr[i] = BLANK_ATTR; end
         cur_r = 0; cur_c = 0; top_r = 0; bot_r = ROWS-1; save_r = 0; save_c = 0;
         pen_attr = BLANK_ATTR; pstate = PS_GROUND; pcount = 0;
         foreach (pvals[i]) pvals[i] = 0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         // compare first: the result of a word never shows in the same cycle
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.cell_char, rsp_bus.cell_attr, rsp_bus.cursor_row,
                    rsp_bus.cursor_col};
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               if (got.cell_char !== w.cell_char || got.cell_attr !== w.cell_attr ||
                   got.cursor_row !== w.cursor_row || got.cursor_col !== w.cursor_col) begin
                  $display("%0t: mismatch expected char %h attr %h row %0d col %0d",
                           $time, w.cell_char, w.cell_attr, w.cursor_row, w.cursor_col);
                  $display("%0t:          actual   char %h attr %h row %0d col %0d",
                           $time, got.cell_char, got.cell_attr, got.cursor_row,
                           got.cursor_col);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            w = '0;
            if (req_bus.cmd == 1'b0) feed_terminal(req_bus.data_byte);
            else if (req_bus.read_row < ROWS && req_bus.read_col < COLS) begin
               w.cell_char = grid_char[req_bus.read_row*COLS + req_bus.read_col];
               w.cell_attr = grid_attr[req_bus.read_row*COLS + req_bus.read_col];
            end
            w.cursor_row = ROW_W'(cur_r);
            w.cursor_col = COL_W'(cur_c);
            expected_words.push_back(w);
         end
      end
   end
endmodule

[tb/tb_ansi_text_terminal_engine.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ansi_text_terminal_engine
// drives directed and random terminal byte streams and cell reads; the
// checker predicts each result word and reports mismatches
// ----------------------------------------------------------------------------
module tb_ansi_text_terminal_engine;
   import tte_pkg::*;

   logic clock;
   logic reset;
   int   fail_count, pending_count;
   int   words_sent;
   bit   quiet_stretch;   // no idling on either side while set

   tte_req_if req_bus();
   tte_rsp_if rsp_bus();

   ansi_text_terminal_engine i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   tte_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard limit: clearing pass plus ~300 words at full-screen cost, many times over
   initial begin
      #400ms;
      $display("*** FAILED ***");
      $finish;
   end

   // result side stalls at random
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 37);
      end
   end

   // send one word, with random idle cycles ahead of it unless quiet_stretch is set
   task automatic send_word(input logic cmd, input logic [7:0] b,
                            input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
      while (!quiet_stretch && $urandom_range(99) < 37) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.data_byte <= b;
      req_bus.read_row  <= r;
      req_bus.read_col  <= c;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   task automatic feed(input logic [7:0] b);
      send_word(1'b0, b, ROW_W'($urandom), COL_W'($urandom));
   endtask

   task automatic feed_text(input string s);
      foreach (s[i]) feed(s[i]);
   endtask

   task automatic read_cell(input int r, input int c);
      send_word(1'b1, 8'($urandom), ROW_W'(r), COL_W'(c));
   endtask

   // a well-formed escape sequence with random parameters
   task automatic random_csi();
      string finals;
      int    np, k;
      finals = "HfABCDJKmrsuMSTLz";
      feed(CH_ESC);
      feed(CH_LBR);
      if ($urandom_range(9) == 0) feed("?");
      np = $urandom_range(3);
      for (k = 0; k < np; k++) begin
         if (k > 0) feed(";");
         case ($urandom_range(5))
            0: feed_text($sformatf("%0d", $urandom_range(99999)));
            1: feed_text($sformatf("%0d", 30 + $urandom_range(17)));
            2: feed_text($sformatf("%0d", 90 + $urandom_range(7)));
            default: feed_text($sformatf("%0d", $urandom_range(30)));
         endcase
      end
      feed(finals[$urandom_range(finals.len()-1)]);
   endtask

   initial begin
      reset = 1'b1;
      quiet_stretch = 1'b0;
      words_sent = 0;
      req_bus.valid = 1'b0;
      req_bus.cmd = 1'b0;
      req_bus.data_byte = '0;
      req_bus.read_row = '0;
      req_bus.read_col = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: glyphs, wrap, controls, colors, region, erase, out-of-grid reads
      feed_text("Hi\tx\010y\r");
      read_cell(0, 0);
      feed_text("\033[31;44;1mA\033[0m\033[97mB\033[m");
      read_cell(0, 1);
      feed_text("\033[1;80Hxy\033[2;5r\033[5;1H\n\033[s\033[99;99H\033[u");
      feed_text("\033[2L\033[T\033[M\033[99999999;1;2;3;4;5;6;7;8;9;;H\033Xq");
      feed_text("\033[5\001\033[1K\033[7K\033[1J\033[9J\033[3r\033[zZ\377\200");
      read_cell(1, 0);
      read_cell(24, 79);
      read_cell(31, 127);
      read_cell(0, 80);

      // random: mostly well-formed sequences and text, some noise and reads
      quiet_stretch = 1'b1;
      while (words_sent < 300) begin
         if (words_sent >= 220) quiet_stretch = 1'b0;
         case ($urandom_range(9))
            0, 1, 2: random_csi();
            3, 4: feed(8'(32'h20 + $urandom_range(94)));
            5: feed(8'($urandom_range(15)));
            6: feed(8'($urandom));
            7: read_cell($urandom_range(31), $urandom_range(127));
            default: read_cell($urandom_range(ROWS-1), $urandom_range(COLS-1));
         endcase
      end
      req_bus.valid <= 1'b0;

      // drain and let the last word settle
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2100) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

[sim.f]
hdl/tte_pkg.sv
hdl/tte_if.sv
hdl/tte_front.sv
hdl/tte_queue.sv
hdl/tte_back.sv
hdl/ansi_text_terminal_engine.sv
tb/tte_checker.sv
tb/tb_ansi_text_terminal_engine.sv
